FILE: design/utf8_stream_decoder_core_assert.svh
// assertion macros for the utf8 stream decoder rtl, used by utf8d_back
// expects clk and rst_n in the scope of each use
`ifndef UTF8_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_STREAM_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define UTF8SDC_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("utf8 decoder check failed");

// next-cycle implication
`define UTF8SDC_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("utf8 decoder check failed");

`endif

FILE: design/utf8d_pkg.sv
// types and constants of the utf8 stream decoder
// no dependencies
`default_nettype none

package utf8d_pkg;

  localparam int CpW  = 21;
  localparam int BytW = 8;

  typedef logic [CpW-1:0]  cp_t;
  typedef logic [BytW-1:0] byte_t;

  // expected length of the open sequence
  typedef enum logic [2:0] {
    SEQ_NONE  = 3'd0,
    SEQ_TWO   = 3'd2,
    SEQ_THREE = 3'd3,
    SEQ_FOUR  = 3'd4
  } seq_len_t;

  localparam byte_t CONT_MASK  = 8'hC0;
  localparam byte_t CONT_TAG   = 8'h80;
  localparam byte_t LEAD2_MASK = 8'hE0;
  localparam byte_t LEAD2_TAG  = 8'hC0;
  localparam byte_t LEAD3_MASK = 8'hF0;
  localparam byte_t LEAD3_TAG  = 8'hE0;
  localparam byte_t LEAD4_MASK = 8'hF8;
  localparam byte_t LEAD4_TAG  = 8'hF0;

  localparam cp_t MAX_ONE   = 21'h00007F;
  localparam cp_t MAX_TWO   = 21'h0007FF;
  localparam cp_t MAX_THREE = 21'h00FFFF;

  // command for the back end: inv_cnt invalid results, then an optional tail result
  typedef struct packed {
    logic [2:0] inv_cnt;
    logic       has_tail;
    cp_t        tail_cp;
    logic       tail_inv;
    logic       tail_eos;
  } cmd_t;

endpackage

`default_nettype wire

FILE: design/utf8d_ifs.sv
// request channels of the utf8 stream decoder: raw bytes in, code points out
// depends on utf8d_pkg
`default_nettype none

interface utf8d_byte_if import utf8d_pkg::*;;
  logic  valid;
  logic  ready;
  byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface utf8d_cp_if import utf8d_pkg::*;;
  logic valid;
  logic ready;
  cp_t  code_point;
  logic invalid;
  logic end_of_string;
  logic last;

  modport source (output valid, output code_point, output invalid,
                  output end_of_string, output last, input ready);
  modport sink (input valid, input code_point, input invalid,
                input end_of_string, input last, output ready);
endinterface

`default_nettype wire

FILE: design/utf8d_front.sv
// front end: accepts bytes, tracks the open sequence, classifies each byte
// into a command for the back end; depends on utf8d_pkg and utf8d_ifs
`default_nettype none

module utf8d_front import utf8d_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  utf8d_byte_if.sink   in_if,
  input  logic         q_full,
  output logic         push,
  output cmd_t         push_cmd
);

  seq_len_t   seq_len_r, seq_len_nxt;
  logic [1:0] held_r, held_nxt;
  cp_t        part_r, part_nxt;

  byte_t      b;
  logic       accept;
  logic       is_cont;
  logic       lead;
  logic       overlong;
  logic [2:0] held_inc;
  cp_t        v;
  cmd_t       cmd;

  assign b        = in_if.in_byte;
  assign is_cont  = (b & CONT_MASK) == CONT_TAG;
  assign v        = {part_r[CpW-7:0], b[5:0]};
  assign held_inc = {1'b0, held_r} + 3'd1;
  assign overlong = (v <= MAX_ONE) ||
                    ((seq_len_r == SEQ_THREE) && (v <= MAX_TWO)) ||
                    ((seq_len_r == SEQ_FOUR) && (v <= MAX_THREE));

  always_comb begin
    cmd         = '0;
    seq_len_nxt = seq_len_r;
    held_nxt    = held_r;
    part_nxt    = part_r;
    lead        = 1'b0;

    if (seq_len_r != SEQ_NONE) begin
      if (is_cont) begin
        if (held_inc >= 3'(seq_len_r)) begin
          if (overlong) begin
            cmd.inv_cnt = 3'(seq_len_r);
          end else begin
            cmd.has_tail = 1'b1;
            cmd.tail_cp  = v;
          end
          seq_len_nxt = SEQ_NONE;
          held_nxt    = 2'd0;
          part_nxt    = '0;
        end else begin
          part_nxt = v;
          held_nxt = held_inc[1:0];
        end
      end else begin
        // interrupted sequence: one invalid per byte held
        cmd.inv_cnt = {1'b0, held_r};
        seq_len_nxt = SEQ_NONE;
        held_nxt    = 2'd0;
        part_nxt    = '0;
        lead        = 1'b1;
      end
    end else begin
      lead = 1'b1;
    end

    if (lead) begin
      if (b == '0) begin
        cmd.has_tail = 1'b1;
        cmd.tail_eos = 1'b1;
      end else if (!b[BytW-1]) begin
        cmd.has_tail = 1'b1;
        cmd.tail_cp  = {{(CpW-BytW){1'b0}}, b};
      end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
        seq_len_nxt = SEQ_TWO;
        held_nxt    = 2'd1;
        part_nxt    = {{(CpW-5){1'b0}}, b[4:0]};
      end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
        seq_len_nxt = SEQ_THREE;
        held_nxt    = 2'd1;
        part_nxt    = {{(CpW-4){1'b0}}, b[3:0]};
      end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
        seq_len_nxt = SEQ_FOUR;
        held_nxt    = 2'd1;
        part_nxt    = {{(CpW-3){1'b0}}, b[2:0]};
      end else begin
        cmd.has_tail = 1'b1;
        cmd.tail_inv = 1'b1;
      end
    end
  end

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && in_if.ready;
  assign push        = accept && ((cmd.inv_cnt != 3'd0) || cmd.has_tail);
  assign push_cmd    = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r <= SEQ_NONE;
      held_r    <= 2'd0;
      part_r    <= '0;
    end else if (accept) begin
      seq_len_r <= seq_len_nxt;
      held_r    <= held_nxt;
      part_r    <= part_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/utf8d_queue.sv
// two-entry command queue between front and back end
// depends on utf8d_pkg
`default_nettype none

module utf8d_queue import utf8d_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic pop
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = cnt_r == 2'd2;
  assign q_valid = cnt_r != 2'd0;
  assign q_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/utf8d_back.sv
// back end: expands each command into results behind an output register
// depends on utf8d_pkg, utf8d_ifs and the assertion macro header
`default_nettype none

`include "utf8_stream_decoder_core_assert.svh"

module utf8d_back import utf8d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        pop,
  utf8d_cp_if.source  out_if
);

  logic [1:0] idx_r;
  logic       out_valid_r;
  cp_t        out_cp_r;
  logic       out_inv_r;
  logic       out_eos_r;
  logic       out_last_r;

  logic [2:0] total;
  logic       inv_slot;
  logic       is_last;
  logic       load;

  assign total    = q_cmd.inv_cnt + {2'b00, q_cmd.has_tail};
  assign inv_slot = {1'b0, idx_r} < q_cmd.inv_cnt;
  assign is_last  = {1'b0, idx_r} == (total - 3'd1);
  assign load     = q_valid && (!out_valid_r || out_if.ready);
  assign pop      = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= is_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_cp_r   <= inv_slot ? '0 : q_cmd.tail_cp;
      out_inv_r  <= inv_slot ? 1'b1 : q_cmd.tail_inv;
      out_eos_r  <= inv_slot ? 1'b0 : q_cmd.tail_eos;
      out_last_r <= is_last;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.code_point    = out_cp_r;
  assign out_if.invalid       = out_inv_r;
  assign out_if.end_of_string = out_eos_r;
  assign out_if.last          = out_last_r;

  `UTF8SDC_ASSERT_NOW(a_no_empty_cmd, q_valid, total != 3'd0)
  `UTF8SDC_ASSERT_NEXT(a_load_shows, load, out_valid_r)
  `UTF8SDC_ASSERT_NEXT(a_idx_holds, q_valid && !load, $stable(idx_r))
  `UTF8SDC_ASSERT_NOW(a_inv_clean, out_valid_r && out_inv_r,
                      out_cp_r == '0 && !out_eos_r)

endmodule

`default_nettype wire

FILE: design/utf8_stream_decoder_core.sv
// utf8 stream decoder: one raw byte in per request, zero to four code point results out
//
// in_if carries one byte per request (valid/ready, accepted when both are high).
// out_if carries one result per request: code_point, invalid, end_of_string and
// last, which marks the final result caused by one input byte. A byte that only
// opens or extends a sequence causes no result.
// the first result of a byte passes the command queue and then the output register.
// throughput: one byte per cycle while each byte causes at most one result and the
// receiver is ready; a byte that causes several results is expanded one result at a
// time by the single output register, and the two-entry command queue absorbs short
// bursts before in_if.ready drops.
// when the receiver stalls, the output register holds its result, the queue
// fills, and in_if.ready falls once both queue entries are taken.
// synchronous active-low reset closes any open sequence and empties the queue
// and the output register.
// depends on utf8d_pkg, utf8d_ifs, utf8d_front, utf8d_queue, utf8d_back
`default_nettype none

module utf8_stream_decoder_core import utf8d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  utf8d_byte_if.sink  in_if,
  utf8d_cp_if.source  out_if
);

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  utf8d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  utf8d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  utf8d_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .out_if  (out_if)
  );

endmodule

`default_nettype wire

FILE: test/tb_utf8_stream_decoder_core.sv
// testbench for utf8_stream_decoder_core: directed and random byte streams, results
// checked in order against a decoder written here; depends on utf8d_pkg, utf8d_ifs
// and the decoder rtl
`timescale 1ns / 100ps

module tb_utf8_stream_decoder_core;
  import utf8d_pkg::*;

  localparam int TotalBytes  = 170;
  localparam int HoldAt      = 40;
  localparam int HoldCycles  = 60;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 8;

  typedef struct packed {
    cp_t  code_point;
    logic invalid;
    logic end_of_string;
    logic last;
  } cp_result_t;

  typedef struct {
    byte_t data;
    bit    drain_first;
    int    phase;
  } byte_req_t;

  logic clk;
  logic rst_n;

  utf8d_byte_if byte_ch ();
  utf8d_cp_if   cp_ch ();

  utf8_stream_decoder_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (byte_ch),
    .out_if (cp_ch)
  );

  int send_idle_pct[3] = '{10, 67, 0};
  int recv_idle_pct[3] = '{67, 10, 0};

  byte_req_t  pending[$];
  cp_result_t cp_expected[$];
  cp_result_t byte_results[$];

  seq_len_t   open_len = SEQ_NONE;
  logic [1:0] held_cnt = '0;
  cp_t        acc_val  = '0;

  bit byte_taken    = 0;
  int bytes_in      = 0;
  int offered_phase = 0;
  int cur_phase     = 0;
  int err_cnt       = 0;
  int quiet_cycles  = 0;
  int hold_left     = 0;
  bit hold_done     = 0;

  function automatic void add_result(cp_t cp, logic inv, logic eos);
    byte_results.push_back('{code_point: cp, invalid: inv, end_of_string: eos, last: 1'b0});
  endfunction

  // decoder state update for one byte, results appended to cp_expected
  function automatic void decode_byte(byte_t b);
    cp_t v;
    int  held;
    byte_results.delete();
    if (open_len != SEQ_NONE && (b & CONT_MASK) == CONT_TAG) begin
      v = (acc_val << 6) | cp_t'(b[5:0]);
      held = held_cnt + 1;
      if (held >= open_len) begin
        if (v <= MAX_ONE || (open_len == SEQ_THREE && v <= MAX_TWO) ||
            (open_len == SEQ_FOUR && v <= MAX_THREE)) begin
          repeat (int'(open_len)) add_result('0, 1'b1, 1'b0);
        end else begin
          add_result(v, 1'b0, 1'b0);
        end
        open_len = SEQ_NONE;
        held_cnt = '0;
        acc_val  = '0;
      end else begin
        acc_val  = v;
        held_cnt = 2'(held);
      end
    end else begin
      // interrupted sequence: one invalid per byte held
      if (open_len != SEQ_NONE) begin
        repeat (held_cnt) add_result('0, 1'b1, 1'b0);
        open_len = SEQ_NONE;
        held_cnt = '0;
        acc_val  = '0;
      end
      if (b == '0) begin
        add_result('0, 1'b0, 1'b1);
      end else if (!b[7]) begin
        add_result(cp_t'(b), 1'b0, 1'b0);
      end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
        open_len = SEQ_TWO;
        held_cnt = 2'd1;
        acc_val  = cp_t'(b & ~LEAD2_MASK);
      end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
        open_len = SEQ_THREE;
        held_cnt = 2'd1;
        acc_val  = cp_t'(b & ~LEAD3_MASK);
      end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
        open_len = SEQ_FOUR;
        held_cnt = 2'd1;
        acc_val  = cp_t'(b & ~LEAD4_MASK);
      end else begin
        add_result('0, 1'b1, 1'b0);
      end
    end
    if (byte_results.size() > 0) byte_results[$].last = 1'b1;
    foreach (byte_results[i]) cp_expected.push_back(byte_results[i]);
  endfunction

  function automatic void queue_byte(byte_t b);
    pending.push_back('{data: b, drain_first: 1'b0, phase: 0});
  endfunction

  function automatic byte_t lead_byte(int len);
    case (len)
      2:       return LEAD2_TAG | byte_t'($urandom_range(31));
      3:       return LEAD3_TAG | byte_t'($urandom_range(15));
      default: return LEAD4_TAG | byte_t'($urandom_range(7));
    endcase
  endfunction

  function automatic byte_t cont_byte();
    return CONT_TAG | byte_t'($urandom_range(63));
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // sender
  always @(negedge clk) begin
    bit        go;
    byte_req_t nxt;
    go = 1'b0;
    if (rst_n && (!byte_ch.valid || byte_taken)) begin
      byte_taken = 1'b0;
      if (pending.size() > 0) begin
        nxt = pending[0];
        go = !(nxt.drain_first && cp_expected.size() != 0) &&
             ($urandom_range(99) >= send_idle_pct[nxt.phase]);
        if (go) begin
          void'(pending.pop_front());
          offered_phase = nxt.phase;
          byte_ch.in_byte <= nxt.data;
        end
      end
      byte_ch.valid <= go;
    end
  end

  // receiver, with one long hold-off to back up the decoder
  always @(negedge clk) begin
    if (!rst_n) begin
      cp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      cp_ch.ready <= 1'b0;
    end else if (!hold_done && bytes_in >= HoldAt) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      cp_ch.ready <= 1'b0;
    end else begin
      cp_ch.ready <= ($urandom_range(99) >= recv_idle_pct[cur_phase]);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    bit         busy;
    cp_result_t exp_res;
    if (rst_n) begin
      busy = 1'b0;
      if (cp_ch.valid && cp_ch.ready) begin
        busy = 1'b1;
        if (cp_expected.size() == 0) begin
          $error("unexpected result: code_point %h invalid %b end_of_string %b last %b",
                 cp_ch.code_point, cp_ch.invalid, cp_ch.end_of_string, cp_ch.last);
          err_cnt++;
        end else begin
          exp_res = cp_expected.pop_front();
          if (cp_ch.code_point !== exp_res.code_point) begin
            $error("code_point: expected %h, got %h", exp_res.code_point, cp_ch.code_point);
            err_cnt++;
          end
          if (cp_ch.invalid !== exp_res.invalid) begin
            $error("invalid: expected %b, got %b", exp_res.invalid, cp_ch.invalid);
            err_cnt++;
          end
          if (cp_ch.end_of_string !== exp_res.end_of_string) begin
            $error("end_of_string: expected %b, got %b", exp_res.end_of_string,
                   cp_ch.end_of_string);
            err_cnt++;
          end
          if (cp_ch.last !== exp_res.last) begin
            $error("last: expected %b, got %b", exp_res.last, cp_ch.last);
            err_cnt++;
          end
        end
      end
      if (byte_ch.valid && byte_ch.ready) begin
        busy = 1'b1;
        decode_byte(byte_ch.in_byte);
        byte_taken = 1'b1;
        bytes_in++;
        cur_phase = offered_phase;
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("utf8_stream_decoder_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    byte_t b;
    int    len;
    int    n;
    byte_ch.valid   = 1'b0;
    byte_ch.in_byte = '0;
    cp_ch.ready     = 1'b0;

    // field extremes, bad leads, good sequences of each length, largest value,
    // overlong forms, a surrogate, and a sequence cut short by a nul
    begin
      byte_t directed[26];
      directed = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                   8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hC0, 8'h80, 8'hF0, 8'h80, 8'h80,
                   8'h80, 8'hED, 8'hA0, 8'h80, 8'hF0, 8'h90, 8'h80, 8'h00};
      foreach (directed[i]) queue_byte(directed[i]);
    end

    while (pending.size() < TotalBytes) begin
      case ($urandom_range(9))
        0, 1: queue_byte(byte_t'($urandom_range(1, 127)));
        2: queue_byte('0);
        3, 4, 5: begin
          len = $urandom_range(2, 4);
          queue_byte(lead_byte(len));
          repeat (len - 1) queue_byte(cont_byte());
        end
        6: queue_byte(byte_t'($urandom_range(255)));
        default: begin
          // truncated sequence followed by a byte that is not a continuation
          len = $urandom_range(2, 4);
          queue_byte(lead_byte(len));
          repeat ($urandom_range(len - 2)) queue_byte(cont_byte());
          do b = byte_t'($urandom_range(255)); while ((b & CONT_MASK) == CONT_TAG);
          queue_byte(b);
        end
      endcase
    end

    n = pending.size();
    foreach (pending[i]) pending[i].phase = (i * 3) / n;
    for (int i = 1; i < n; i++)
      if (pending[i].phase != pending[i-1].phase) pending[i].drain_first = 1'b1;

    @(posedge rst_n);
    while (pending.size() != 0 || byte_ch.valid || cp_expected.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_cnt == 0 && cp_expected.size() == 0) begin
      $display("utf8_stream_decoder_core verification clean");
    end else begin
      $display("utf8_stream_decoder_core verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/utf8d_pkg.sv
design/utf8d_ifs.sv
design/utf8d_front.sv
design/utf8d_queue.sv
design/utf8d_back.sv
design/utf8_stream_decoder_core.sv
test/tb_utf8_stream_decoder_core.sv
